[rtl/core/fvsg_pkg.sv]
// Shared types, constants and table functions for the four-voice sound generator.
// No dependencies.
package fvsg_pkg;

	localparam int OUTPUT_RATE_DEF   = 44100;
	localparam int MACHINE_CLOCK_DEF = 4194304;
	localparam int FRAME_DIVIDE_DEF  = 8192;

	localparam logic [14:0] LFSR_SEED = 15'h7FFF;
	localparam logic [11:0] FREQ_MAX  = 12'd2047;
	localparam logic [10:0] MIX_LIMIT = 11'd960;

	typedef enum logic [1:0] {
		CFG_MIXER = 2'd0,
		CFG_PAN   = 2'd1,
		CFG_POWER = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]        ven;
		logic [3:0]        con;
		logic [2:0][10:0]  freq;
		logic [2:0][13:0]  per;
		logic [1:0][1:0]   duty_sel;
		logic [1:0][2:0]   duty_idx;
		logic [2:0][3:0]   env_vol;
		logic [2:0]        env_up;
		logic [2:0][2:0]   env_per;
		logic [2:0][2:0]   env_cnt;
		logic [3:0][8:0]   len;
		logic [3:0]        len_on;
		logic [6:0]        swp_set;
		logic [3:0]        swp_cnt;
		logic [10:0]       swp_shadow;
		logic              swp_act;
		logic [1:0]        wave_lvl;
		logic [4:0]        wave_pos;
		logic [7:0]        noise_set;
		logic [21:0]       noise_cnt;
		logic [14:0]       lfsr;
		logic [2:0]        frame_step;
	} apu_st_t;

	typedef struct packed {
		logic               [3:0]  status;
		logic                      smp_valid;
		logic signed        [10:0] mix;
	} res_t;

	function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
		logic [7:0] row;
		case (sel)
			2'd0:    row = 8'b1000_0000;
			2'd1:    row = 8'b1000_0001;
			2'd2:    row = 8'b1110_0001;
			default: row = 8'b0111_1110;
		endcase
		return row[pos];
	endfunction

	function automatic logic [21:0] noise_reload(input logic [7:0] set);
		logic [6:0] dv;
		case (set[2:0])
			3'd0:    dv = 7'd8;
			3'd1:    dv = 7'd16;
			3'd2:    dv = 7'd32;
			3'd3:    dv = 7'd48;
			3'd4:    dv = 7'd64;
			3'd5:    dv = 7'd80;
			3'd6:    dv = 7'd96;
			default: dv = 7'd112;
		endcase
		return {15'd0, dv} << set[7:4];
	endfunction

	function automatic logic [13:0] tone_reload(input logic [10:0] f, input logic wave);
		logic [11:0] d;
		d = 12'd2048 - {1'b0, f};
		return wave ? {1'b0, d, 1'b0} : {d, 2'b00};
	endfunction

	function automatic logic [11:0] sweep_next(input logic [10:0] f, input logic [6:0] set);
		logic [10:0] delta;
		delta = f >> set[2:0];
		return set[3] ? ({1'b0, f} - {1'b0, delta}) : ({1'b0, f} + {1'b0, delta});
	endfunction

endpackage

[rtl/core/four_voice_sound_generator.sv]
// Top level of the four-voice sound generator: state core, mix register and output stage.
// Depends on fvsg_pkg, fvsg_core and fvsg_scale.
// Pipeline: an accepted item's result is registered in the mix register, then in the output registers.
// Throughput: one item per cycle while out_ready is high; a stalled output holds both stages.
// Reset: arst_n clears all voice state, the LFSR loads all ones, power_q sets to one.
module four_voice_sound_generator #(
	parameter int OUTPUT_RATE   = fvsg_pkg::OUTPUT_RATE_DEF,
	parameter int MACHINE_CLOCK = fvsg_pkg::MACHINE_CLOCK_DEF,
	parameter int FRAME_DIVIDE  = fvsg_pkg::FRAME_DIVIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [5:0]        reg_addr,
	input  logic [7:0]        reg_value,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [7:0]        wr_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        channel_active,
	output logic              sample_valid,
	output logic signed [15:0] sample
);
	fvsg_pkg::res_t res, res_s1;
	logic           valid_s1, valid_s2, load_s2, accept;
	logic signed [15:0] smp;

	assign load_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;
	assign accept   = in_valid && in_ready;
	assign out_valid = valid_s2;

	fvsg_core #(
		.OUTPUT_RATE(OUTPUT_RATE),
		.MACHINE_CLOCK(MACHINE_CLOCK),
		.FRAME_DIVIDE(FRAME_DIVIDE)
	) u_core (
		.clk(clk), .arst_n(arst_n), .accept(accept), .kind(kind),
		.reg_addr(reg_addr), .reg_value(reg_value),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .res(res)
	);

	fvsg_scale u_scale (.mix(res_s1.mix), .sample(smp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (load_s2) valid_s1 <= 1'b0;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_s1 <= res;
		if (load_s2 && valid_s1) begin
			channel_active <= res_s1.status;
			sample_valid <= res_s1.smp_valid;
			sample <= smp;
		end
	end

	a_write_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind |=> valid_s1 && !res_s1.smp_valid)
		else $error("write item produced a sample");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_valid |-> sample == 16'sd0)
		else $error("sample nonzero without sample_valid");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != 16'sh8000)
		else $error("sample out of range");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1 && $stable(res_s1))
		else $error("mix register overwritten while stalled");

endmodule

[rtl/core/fvsg_core.sv]
// Voice, frame sequencer and sample-rate state; each accepted item updates it.
// Depends on fvsg_pkg.
module fvsg_core #(
	parameter int OUTPUT_RATE   = fvsg_pkg::OUTPUT_RATE_DEF,
	parameter int MACHINE_CLOCK = fvsg_pkg::MACHINE_CLOCK_DEF,
	parameter int FRAME_DIVIDE  = fvsg_pkg::FRAME_DIVIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              kind,
	input  logic [5:0]        reg_addr,
	input  logic [7:0]        reg_value,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [7:0]        wr_data,
	output fvsg_pkg::res_t    res
);
	localparam int FCW = $clog2(FRAME_DIVIDE + 1);
	localparam int RW  = $clog2(MACHINE_CLOCK + OUTPUT_RATE + 1);
	localparam logic [FCW-1:0] FD   = FCW'(FRAME_DIVIDE);
	localparam logic [RW-1:0]  RINC = RW'(OUTPUT_RATE);
	localparam logic [RW-1:0]  RMAX = RW'(MACHINE_CLOCK);
	localparam fvsg_pkg::apu_st_t ST_RESET = '{lfsr: fvsg_pkg::LFSR_SEED, default: '0};

	localparam logic [5:0] A_SWEEP = 6'h10, A_DUTY1 = 6'h11, A_ENV1 = 6'h12,
		A_FLO1 = 6'h13, A_FHI1 = 6'h14, A_DUTY2 = 6'h16, A_ENV2 = 6'h17,
		A_FLO2 = 6'h18, A_FHI2 = 6'h19, A_WON = 6'h1A, A_WLEN = 6'h1B,
		A_WLVL = 6'h1C, A_FLO3 = 6'h1D, A_FHI3 = 6'h1E, A_NLEN = 6'h20,
		A_ENV4 = 6'h21, A_NSET = 6'h22, A_NCTL = 6'h23, A_WAVE = 6'h30;

	fvsg_pkg::apu_st_t st_q, st_d;
	logic [7:0]     wave_q [16];
	logic [FCW-1:0] fcnt_q, fcnt_d;
	logic [RW-1:0]  racc_q, racc_d;
	logic [7:0]     mixvol_q, pan_q;
	logic           power_q;
	logic           smp_d;

	function automatic fvsg_pkg::apu_st_t trig(input fvsg_pkg::apu_st_t s, input logic [1:0] v);
		logic [1:0] e;
		e = (v == 2'd3) ? 2'd2 : v;
		s.ven[v] = s.con[v];
		if (v != 2'd3) s.per[v] = fvsg_pkg::tone_reload(s.freq[v], v == 2'd2);
		if (v < 2'd2) s.duty_idx[v[0]] = 3'd0;
		if (v == 2'd2) s.wave_pos = 5'd0;
		else s.env_cnt[e] = s.env_per[e];
		if (s.len[v] == 9'd0) s.len[v] = (v == 2'd2) ? 9'd256 : 9'd64;
		if (v == 2'd0) begin
			s.swp_shadow = s.freq[0];
			s.swp_cnt = (s.swp_set[6:4] != 3'd0) ? {1'b0, s.swp_set[6:4]} : 4'd8;
			s.swp_act = (s.swp_set[6:4] != 3'd0) || (s.swp_set[2:0] != 3'd0);
			if (s.swp_set[2:0] != 3'd0 &&
				fvsg_pkg::sweep_next(s.swp_shadow, s.swp_set) > fvsg_pkg::FREQ_MAX)
				s.ven[0] = 1'b0;
		end
		if (v == 2'd3) begin
			s.noise_cnt = fvsg_pkg::noise_reload(s.noise_set);
			s.lfsr = fvsg_pkg::LFSR_SEED;
		end
		return s;
	endfunction

	function automatic fvsg_pkg::apu_st_t env_wr(input fvsg_pkg::apu_st_t s,
		input logic [1:0] e, input logic [1:0] v, input logic [7:0] val);
		s.env_vol[e] = val[7:4];
		s.env_up[e] = val[3];
		s.env_per[e] = val[2:0];
		s.con[v] = val[7:3] != 5'd0;
		if (!s.con[v]) s.ven[v] = 1'b0;
		return s;
	endfunction

	always_comb begin
		fvsg_pkg::apu_st_t s;
		logic [11:0] nf;
		logic        x;
		logic [1:0]  own;
		s = st_q;
		fcnt_d = fcnt_q;
		racc_d = racc_q;
		smp_d = 1'b0;
		nf = 12'd0;
		x = 1'b0;
		own = 2'd0;
		if (kind) begin
			if (reg_addr >= A_WAVE) begin
				// wave RAM written in the clocked block
			end else begin
				case (reg_addr)
					A_SWEEP: s.swp_set = reg_value[6:0];
					A_DUTY1: begin
						s.duty_sel[0] = reg_value[7:6];
						s.len[0] = 9'd64 - {3'd0, reg_value[5:0]};
					end
					A_ENV1: s = env_wr(s, 2'd0, 2'd0, reg_value);
					A_FLO1: s.freq[0][7:0] = reg_value;
					A_FHI1: begin
						s.freq[0][10:8] = reg_value[2:0];
						s.len_on[0] = reg_value[6];
						if (reg_value[7]) s = trig(s, 2'd0);
					end
					A_DUTY2: begin
						s.duty_sel[1] = reg_value[7:6];
						s.len[1] = 9'd64 - {3'd0, reg_value[5:0]};
					end
					A_ENV2: s = env_wr(s, 2'd1, 2'd1, reg_value);
					A_FLO2: s.freq[1][7:0] = reg_value;
					A_FHI2: begin
						s.freq[1][10:8] = reg_value[2:0];
						s.len_on[1] = reg_value[6];
						if (reg_value[7]) s = trig(s, 2'd1);
					end
					A_WON: begin
						s.con[2] = reg_value[7];
						if (!reg_value[7]) s.ven[2] = 1'b0;
					end
					A_WLEN: s.len[2] = 9'd256 - {1'b0, reg_value};
					A_WLVL: s.wave_lvl = reg_value[6:5];
					A_FLO3: s.freq[2][7:0] = reg_value;
					A_FHI3: begin
						s.freq[2][10:8] = reg_value[2:0];
						s.len_on[2] = reg_value[6];
						if (reg_value[7]) s = trig(s, 2'd2);
					end
					A_NLEN: s.len[3] = 9'd64 - {3'd0, reg_value[5:0]};
					A_ENV4: s = env_wr(s, 2'd2, 2'd3, reg_value);
					A_NSET: s.noise_set = reg_value;
					A_NCTL: begin
						s.len_on[3] = reg_value[6];
						if (reg_value[7]) s = trig(s, 2'd3);
					end
					default: ;
				endcase
			end
		end else if (power_q) begin
			for (int t = 0; t < 3; t++) begin
				if (s.ven[t] && s.con[t]) begin
					if (s.per[t] <= 14'd1) begin
						s.per[t] = fvsg_pkg::tone_reload(s.freq[t], t == 2);
						if (t < 2) s.duty_idx[t] = s.duty_idx[t] + 3'd1;
						else s.wave_pos = s.wave_pos + 5'd1;
					end else begin
						s.per[t] = s.per[t] - 14'd1;
					end
				end
			end
			if (s.ven[3] && s.con[3]) begin
				if (s.noise_cnt <= 22'd1) begin
					x = s.lfsr[0] ^ s.lfsr[1];
					s.noise_cnt = fvsg_pkg::noise_reload(s.noise_set);
					s.lfsr = {x, s.lfsr[14:1]};
					if (s.noise_set[3]) s.lfsr[6] = x;
				end else begin
					s.noise_cnt = s.noise_cnt - 22'd1;
				end
			end
			fcnt_d = fcnt_q + FCW'(1);
			if (fcnt_d >= FD) begin
				fcnt_d = fcnt_d - FD;
				s.frame_step = s.frame_step + 3'd1;
				if (!s.frame_step[0]) begin
					for (int v = 0; v < 4; v++) begin
						if (s.len_on[v] && s.len[v] != 9'd0) begin
							s.len[v] = s.len[v] - 9'd1;
							if (s.len[v] == 9'd0) s.ven[v] = 1'b0;
						end
					end
				end
				if ((s.frame_step == 3'd2 || s.frame_step == 3'd6) &&
					s.swp_act && s.swp_set[6:4] != 3'd0) begin
					if (s.swp_cnt <= 4'd1) begin
						s.swp_cnt = {1'b0, s.swp_set[6:4]};
						nf = fvsg_pkg::sweep_next(s.swp_shadow, s.swp_set);
						if (nf > fvsg_pkg::FREQ_MAX) begin
							s.ven[0] = 1'b0;
						end else if (s.swp_set[2:0] != 3'd0) begin
							s.freq[0] = nf[10:0];
							s.swp_shadow = nf[10:0];
							if (fvsg_pkg::sweep_next(nf[10:0], s.swp_set) > fvsg_pkg::FREQ_MAX)
								s.ven[0] = 1'b0;
						end
					end else begin
						s.swp_cnt = s.swp_cnt - 4'd1;
					end
				end
				if (s.frame_step == 3'd7) begin
					for (int e = 0; e < 3; e++) begin
						own = (e == 2) ? 2'd3 : 2'(e);
						if (s.env_per[e] != 3'd0 && s.con[own]) begin
							if (s.env_cnt[e] <= 3'd1) begin
								s.env_cnt[e] = s.env_per[e];
								if (s.env_up[e]) begin
									if (s.env_vol[e] != 4'd15) s.env_vol[e] = s.env_vol[e] + 4'd1;
								end else if (s.env_vol[e] != 4'd0) begin
									s.env_vol[e] = s.env_vol[e] - 4'd1;
								end
							end else begin
								s.env_cnt[e] = s.env_cnt[e] - 3'd1;
							end
						end
					end
				end
			end
			racc_d = racc_q + RINC;
			if (racc_d >= RMAX) begin
				racc_d = racc_d - RMAX;
				smp_d = 1'b1;
			end
		end
		st_d = s;
	end

	always_comb begin
		logic [3:0]        d;
		logic [7:0]        b;
		logic [3:0]        n;
		logic signed [5:0] a;
		logic signed [6:0] sl, sr;
		logic signed [12:0] sm;
		sl = '0;
		sr = '0;
		b = wave_q[st_d.wave_pos[4:1]];
		n = st_d.wave_pos[0] ? b[3:0] : b[7:4];
		for (int v = 0; v < 4; v++) begin
			case (v)
				0, 1:    d = fvsg_pkg::duty_bit(st_d.duty_sel[v], st_d.duty_idx[v]) ?
						st_d.env_vol[v] : 4'd0;
				2:       d = (st_d.wave_lvl == 2'd0) ? 4'd0 : (n >> (st_d.wave_lvl - 2'd1));
				default: d = st_d.lfsr[0] ? 4'd0 : st_d.env_vol[2];
			endcase
			a = (st_d.ven[v] && st_d.con[v]) ? ($signed({1'b0, d, 1'b0}) - 6'sd15) : 6'sd0;
			if (pan_q[v + 4]) sl = sl + 7'(a);
			if (pan_q[v])     sr = sr + 7'(a);
		end
		sm = 13'($signed({2'b00, mixvol_q[6:4]} + 5'd1) * sl)
			+ 13'($signed({2'b00, mixvol_q[2:0]} + 5'd1) * sr);
		if (sm > $signed({2'b00, fvsg_pkg::MIX_LIMIT})) sm = $signed({2'b00, fvsg_pkg::MIX_LIMIT});
		if (sm < -$signed({2'b00, fvsg_pkg::MIX_LIMIT})) sm = -$signed({2'b00, fvsg_pkg::MIX_LIMIT});
		res.status = st_d.ven & st_d.con;
		res.smp_valid = smp_d;
		res.mix = smp_d ? sm[10:0] : 11'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
			fcnt_q <= '0;
			racc_q <= '0;
			mixvol_q <= '0;
			pan_q <= '0;
			power_q <= 1'b1;
			for (int i = 0; i < 16; i++) wave_q[i] <= '0;
		end else begin
			if (accept) begin
				st_q <= st_d;
				fcnt_q <= fcnt_d;
				racc_q <= racc_d;
				if (kind && reg_addr >= A_WAVE) wave_q[reg_addr[3:0]] <= reg_value;
			end
			if (wr_en) begin
				case (wr_index)
					fvsg_pkg::CFG_MIXER: mixvol_q <= wr_data;
					fvsg_pkg::CFG_PAN:   pan_q <= wr_data;
					fvsg_pkg::CFG_POWER: power_q <= wr_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

[rtl/core/fvsg_scale.sv]
// Scales the clamped mix to a 16-bit sample: mix * 32767 / 960, toward zero.
// No dependencies.
module fvsg_scale (
	input  logic signed [10:0] mix,
	output logic signed [15:0] sample
);
	localparam logic [15:0] RECIP15 = 16'd34952;

	logic [9:0]  mag;
	logic [24:0] p;
	logic [18:0] x;
	logic [34:0] prod;
	logic [15:0] q0;
	logic [19:0] r;
	logic [15:0] q;

	always_comb begin
		mag = mix[10] ? 10'(-mix) : mix[9:0];
		p = ({15'd0, mag} << 15) - {15'd0, mag};
		x = p[24:6];
		prod = {16'd0, x} * {19'd0, RECIP15};
		q0 = prod[34:19];
		r = {1'b0, x} - ({4'd0, q0} * 20'd15);
		q = (r >= 20'd15) ? q0 + 16'd1 : q0;
		sample = mix[10] ? -$signed(q) : $signed(q);
	end

endmodule

[dv/four_voice_sound_generator_test.sv]
// Self-checking testbench for four_voice_sound_generator: register writes, ticks and sample mix.
// Depends on fvsg_pkg and the four_voice_sound_generator RTL; an internal predictor checks results.
module four_voice_sound_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RATE       = fvsg_pkg::OUTPUT_RATE_DEF;
	localparam int MCLK       = fvsg_pkg::MACHINE_CLOCK_DEF;
	localparam int FDIV       = fvsg_pkg::FRAME_DIVIDE_DEF;
	localparam int QUIET_MAX  = 4000;
	localparam logic [1:0] CFG_NONE = 2'd3;
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct {
		logic       kind;
		logic [5:0] addr;
		logic [7:0] val;
	} apu_item_t;

	typedef struct {
		logic [3:0]  act;
		logic        sv;
		logic [15:0] smp;
	} apu_res_t;

	logic clk, arst_n;
	logic in_valid, in_ready, kind;
	logic [5:0] reg_addr;
	logic [7:0] reg_value;
	logic wr_en;
	logic [1:0] wr_index;
	logic [7:0] wr_data;
	logic out_valid, out_ready;
	logic [3:0] channel_active;
	logic sample_valid;
	logic signed [15:0] sample;

	four_voice_sound_generator DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .reg_addr(reg_addr), .reg_value(reg_value),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.channel_active(channel_active), .sample_valid(sample_valid), .sample(sample)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// predictor state
	int unsigned p_mixer, p_pan, p_power;
	bit  p_ven[4], p_con[4];
	int unsigned p_freq[3], p_per[3];
	int unsigned p_dsel[2], p_dpos[2];
	int unsigned p_evol[3], p_eup[3], p_eper[3], p_ecnt[3];
	int unsigned p_len[4];
	bit  p_lon[4];
	int unsigned p_swset, p_swcnt, p_swshadow, p_swact;
	int unsigned p_wlvl, p_wpos;
	int unsigned p_wram[16];
	int unsigned p_nset, p_ncnt, p_lfsr;
	int unsigned p_fcnt, p_fstep, p_racc;

	const logic [7:0] duty_rows[4] = '{8'b1000_0000, 8'b1000_0001, 8'b1110_0001, 8'b0111_1110};
	const int unsigned noise_divs[8] = '{8, 16, 32, 48, 64, 80, 96, 112};

	apu_item_t pending[$];
	apu_res_t  expected[$];
	int errors, quiet, in_gap, out_gap, hold_left, accepted;
	bit calm, hold_req;

	function automatic int unsigned period_of(int t);
		return (2048 - (p_freq[t] & 'h7FF)) * (t == 2 ? 2 : 4);
	endfunction

	function automatic int unsigned lfsr_period();
		return noise_divs[p_nset & 7] << ((p_nset >> 4) & 15);
	endfunction

	function automatic int unsigned swept(int unsigned f);
		int unsigned d;
		d = f >> (p_swset & 7);
		return ((p_swset >> 3) & 1) ? f - d : f + d;
	endfunction

	function automatic bit on(int v);
		return p_ven[v] && p_con[v];
	endfunction

	function automatic void set_env(int e, int v, int unsigned x);
		p_evol[e] = (x >> 4) & 15;
		p_eup[e]  = (x >> 3) & 1;
		p_eper[e] = x & 7;
		p_con[v]  = (x & 'hF8) != 0;
		if (!p_con[v]) p_ven[v] = 0;
	endfunction

	function automatic void retrigger(int v);
		int unsigned sp, ss;
		int e;
		p_ven[v] = p_con[v];
		if (v < 3) p_per[v] = period_of(v);
		if (v < 2) p_dpos[v] = 0;
		if (v == 2) p_wpos = 0;
		if (v != 2) begin
			e = (v == 3) ? 2 : v;
			p_ecnt[e] = p_eper[e];
		end
		if (p_len[v] == 0) p_len[v] = (v == 2) ? 256 : 64;
		if (v == 0) begin
			sp = (p_swset >> 4) & 7;
			ss = p_swset & 7;
			p_swshadow = p_freq[0];
			p_swcnt = sp ? sp : 8;
			p_swact = (sp > 0 || ss > 0);
			if (ss > 0 && swept(p_swshadow) > 2047) p_ven[0] = 0;
		end
		if (v == 3) begin
			p_ncnt = lfsr_period();
			p_lfsr = 'h7FFF;
		end
	endfunction

	function automatic void apply_write(int unsigned a, int unsigned x);
		if (a >= 'h30) begin
			p_wram[a & 15] = x;
			return;
		end
		case (a)
			'h10: p_swset = x & 'h7F;
			'h11: begin p_dsel[0] = x >> 6; p_len[0] = 64 - (x & 63); end
			'h12: set_env(0, 0, x);
			'h13: p_freq[0] = (p_freq[0] & 'h700) | x;
			'h14: begin
				p_freq[0] = (p_freq[0] & 'hFF) | ((x & 7) << 8);
				p_lon[0] = (x >> 6) & 1;
				if (x & 'h80) retrigger(0);
			end
			'h16: begin p_dsel[1] = x >> 6; p_len[1] = 64 - (x & 63); end
			'h17: set_env(1, 1, x);
			'h18: p_freq[1] = (p_freq[1] & 'h700) | x;
			'h19: begin
				p_freq[1] = (p_freq[1] & 'hFF) | ((x & 7) << 8);
				p_lon[1] = (x >> 6) & 1;
				if (x & 'h80) retrigger(1);
			end
			'h1A: begin
				p_con[2] = (x & 'h80) != 0;
				if (!p_con[2]) p_ven[2] = 0;
			end
			'h1B: p_len[2] = 256 - x;
			'h1C: p_wlvl = (x >> 5) & 3;
			'h1D: p_freq[2] = (p_freq[2] & 'h700) | x;
			'h1E: begin
				p_freq[2] = (p_freq[2] & 'hFF) | ((x & 7) << 8);
				p_lon[2] = (x >> 6) & 1;
				if (x & 'h80) retrigger(2);
			end
			'h20: p_len[3] = 64 - (x & 63);
			'h21: set_env(2, 3, x);
			'h22: p_nset = x;
			'h23: begin
				p_lon[3] = (x >> 6) & 1;
				if (x & 'h80) retrigger(3);
			end
			default: ;
		endcase
	endfunction

	function automatic void advance_voices();
		int unsigned fb;
		for (int t = 0; t < 3; t++) begin
			if (!on(t)) continue;
			if (p_per[t] <= 1) begin
				p_per[t] = period_of(t);
				if (t < 2) p_dpos[t] = (p_dpos[t] + 1) & 7;
				else p_wpos = (p_wpos + 1) & 31;
			end else p_per[t]--;
		end
		if (on(3)) begin
			if (p_ncnt <= 1) begin
				fb = (p_lfsr ^ (p_lfsr >> 1)) & 1;
				p_ncnt = lfsr_period();
				p_lfsr = ((p_lfsr >> 1) | (fb << 14)) & 'h7FFF;
				if ((p_nset >> 3) & 1) p_lfsr = (p_lfsr & ~(32'd1 << 6)) | (fb << 6);
			end else p_ncnt--;
		end
	endfunction

	function automatic void advance_frame();
		int unsigned sp, ss, nf;
		int owner[3] = '{0, 1, 3};
		p_fstep = (p_fstep + 1) & 7;
		if ((p_fstep & 1) == 0)
			for (int v = 0; v < 4; v++)
				if (p_lon[v] && p_len[v] > 0) begin
					p_len[v]--;
					if (p_len[v] == 0) p_ven[v] = 0;
				end
		if (p_fstep == 2 || p_fstep == 6) begin
			sp = (p_swset >> 4) & 7;
			ss = p_swset & 7;
			if (p_swact && sp > 0) begin
				if (p_swcnt <= 1) begin
					p_swcnt = sp;
					nf = swept(p_swshadow);
					if (nf > 2047) p_ven[0] = 0;
					else if (ss > 0) begin
						p_freq[0] = nf;
						p_swshadow = nf;
						if (swept(nf) > 2047) p_ven[0] = 0;
					end
				end else p_swcnt--;
			end
		end
		if (p_fstep == 7)
			for (int e = 0; e < 3; e++)
				if (p_eper[e] > 0 && p_con[owner[e]]) begin
					if (p_ecnt[e] <= 1) begin
						p_ecnt[e] = p_eper[e];
						if (p_eup[e]) begin
							if (p_evol[e] < 15) p_evol[e]++;
						end else if (p_evol[e] > 0) p_evol[e]--;
					end else p_ecnt[e]--;
				end
	endfunction

	function automatic int level_of(int v);
		int unsigned d, b, n;
		d = 0;
		if (!on(v)) return 0;
		if (v < 2) d = duty_rows[p_dsel[v] & 3][p_dpos[v] & 7] ? p_evol[v] : 0;
		else if (v == 2) begin
			b = p_wram[(p_wpos >> 1) & 15];
			n = (p_wpos & 1) ? (b & 15) : (b >> 4);
			d = (p_wlvl == 0) ? 0 : (n >> (p_wlvl - 1));
		end else d = ((p_lfsr & 1) == 0) ? p_evol[2] : 0;
		return 2 * int'(d) - 15;
	endfunction

	function automatic int mixed_sample();
		int sl, sr, s, a;
		sl = 0;
		sr = 0;
		for (int v = 0; v < 4; v++) begin
			a = level_of(v);
			if ((p_pan >> (v + 4)) & 1) sl += a;
			if ((p_pan >> v) & 1) sr += a;
		end
		s = int'(((p_mixer >> 4) & 7) + 1) * sl + int'((p_mixer & 7) + 1) * sr;
		if (s > 960) s = 960;
		if (s < -960) s = -960;
		return (s * 32767) / 960;
	endfunction

	function automatic apu_res_t apu_step(apu_item_t it);
		apu_res_t r;
		int smp;
		r.sv = 0;
		smp = 0;
		if (it.kind == KIND_WRITE) apply_write(it.addr, it.val);
		else if (p_power) begin
			advance_voices();
			p_fcnt++;
			if (p_fcnt >= FDIV) begin
				p_fcnt -= FDIV;
				advance_frame();
			end
			p_racc += RATE;
			if (p_racc >= MCLK) begin
				p_racc -= MCLK;
				smp = mixed_sample();
				r.sv = 1;
			end
		end
		for (int v = 0; v < 4; v++) r.act[v] = on(v);
		r.smp = smp[15:0];
		return r;
	endfunction

	function automatic void clear_model();
		p_mixer = 0; p_pan = 0; p_power = 1;
		for (int v = 0; v < 4; v++) begin
			p_ven[v] = 0; p_con[v] = 0; p_len[v] = 0; p_lon[v] = 0;
		end
		for (int t = 0; t < 3; t++) begin
			p_freq[t] = 0; p_per[t] = 0;
			p_evol[t] = 0; p_eup[t] = 0; p_eper[t] = 0; p_ecnt[t] = 0;
		end
		for (int t = 0; t < 2; t++) begin p_dsel[t] = 0; p_dpos[t] = 0; end
		for (int i = 0; i < 16; i++) p_wram[i] = 0;
		p_swset = 0; p_swcnt = 0; p_swshadow = 0; p_swact = 0;
		p_wlvl = 0; p_wpos = 0;
		p_nset = 0; p_ncnt = 0; p_lfsr = 'h7FFF;
		p_fcnt = 0; p_fstep = 0; p_racc = 0;
	endfunction

	function automatic void add_item(logic k, logic [5:0] a, logic [7:0] x);
		apu_item_t it;
		it.kind = k;
		it.addr = a;
		it.val = x;
		pending.push_back(it);
	endfunction

	function automatic void add_ticks(int n);
		for (int i = 0; i < n; i++) add_item(KIND_TICK, 6'($urandom_range(0, 63)), 8'($urandom));
	endfunction

	// one voice set up with random content and usually triggered
	function automatic void add_voice_setup();
		logic [5:0] len_a[4]  = '{6'h11, 6'h16, 6'h1B, 6'h20};
		logic [5:0] env_a[4]  = '{6'h12, 6'h17, 6'h1A, 6'h21};
		logic [5:0] lo_a[4]   = '{6'h13, 6'h18, 6'h1D, 6'h22};
		logic [5:0] trig_a[4] = '{6'h14, 6'h19, 6'h1E, 6'h23};
		int v;
		logic [7:0] x;
		v = $urandom_range(0, 3);
		if (v == 0) add_item(KIND_WRITE, 6'h10, 8'($urandom));
		if (v == 2) begin
			add_item(KIND_WRITE, 6'h1C, 8'($urandom));
			add_item(KIND_WRITE, 6'($urandom_range(48, 63)), 8'($urandom));
		end
		add_item(KIND_WRITE, len_a[v], 8'($urandom));
		x = 8'($urandom);
		if ($urandom_range(0, 7) != 0) x = x | (v == 2 ? 8'h80 : 8'h10);
		add_item(KIND_WRITE, env_a[v], x);
		x = 8'($urandom);
		if (v == 3) x[7:4] = 4'($urandom_range(0, 3));
		add_item(KIND_WRITE, lo_a[v], x);
		x = 8'($urandom);
		if (v == 3) x[7:4] = 4'($urandom_range(0, 3));
		if ($urandom_range(0, 7) != 0) x[7] = 1'b1;
		add_item(KIND_WRITE, trig_a[v], x);
		add_ticks($urandom_range(20, 150));
	endfunction

	task automatic drain();
		while (pending.size() != 0 || in_valid || expected.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [7:0] d);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		case (idx)
			fvsg_pkg::CFG_MIXER: p_mixer = d;
			fvsg_pkg::CFG_PAN:   p_pan = d;
			fvsg_pkg::CFG_POWER: p_power = d & 1;
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// accept items, predict, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				quiet = 0;
				if (expected.size() == 0) begin
					$error("result with no item pending: act=%h sv=%b smp=%0d",
						channel_active, sample_valid, sample);
					errors++;
				end else begin
					apu_res_t e;
					e = expected.pop_front();
					if (channel_active !== e.act) begin
						$error("channel_active: expected %h, got %h", e.act, channel_active);
						errors++;
					end
					if (sample_valid !== e.sv) begin
						$error("sample_valid: expected %b, got %b", e.sv, sample_valid);
						errors++;
					end
					if (sample !== e.smp) begin
						$error("sample: expected %0d, got %0d", $signed(e.smp), sample);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				apu_item_t it;
				it.kind = kind;
				it.addr = reg_addr;
				it.val = reg_value;
				expected.push_back(apu_step(it));
				accepted = 1;
				quiet = 0;
			end else if (in_valid || expected.size() != 0) begin
				quiet++;
				if (quiet >= QUIET_MAX) begin
					$display("four_voice_sound_generator_test: errors");
					$finish;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || accepted)) begin
			logic nv;
			accepted = 0;
			nv = 1'b0;
			if (in_gap > 0) in_gap--;
			else if (pending.size() != 0) begin
				apu_item_t it;
				it = pending.pop_front();
				kind <= it.kind;
				reg_addr <= it.addr;
				reg_value <= it.val;
				nv = 1'b1;
				if (!calm && $urandom_range(0, 20) == 0) in_gap = $urandom_range(1, 12);
			end
			in_valid <= nv;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && hold_left == 0) begin
				hold_left = 200;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 12);
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		reg_addr = '0;
		reg_value = '0;
		wr_en = 1'b0;
		wr_index = fvsg_pkg::CFG_MIXER;
		wr_data = '0;
		out_ready = 1'b0;
		errors = 0; quiet = 0; in_gap = 0; out_gap = 0; hold_left = 0; accepted = 0;
		calm = 0; hold_req = 0;
		clear_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, unused addresses, power-off ticks
		cfg_write(fvsg_pkg::CFG_MIXER, 8'hFF);
		cfg_write(fvsg_pkg::CFG_PAN, 8'hFF);
		add_item(KIND_WRITE, 6'h00, 8'hFF);
		add_item(KIND_WRITE, 6'h0F, 8'h00);
		add_item(KIND_WRITE, 6'h15, 8'hFF);
		add_item(KIND_WRITE, 6'h1F, 8'hFF);
		add_item(KIND_WRITE, 6'h24, 8'hFF);
		add_item(KIND_WRITE, 6'h2F, 8'hFF);
		add_item(KIND_WRITE, 6'h30, 8'hF0);
		add_item(KIND_WRITE, 6'h3F, 8'h0F);
		add_item(KIND_WRITE, 6'h12, 8'hF0);
		add_item(KIND_WRITE, 6'h13, 8'hFF);
		add_item(KIND_WRITE, 6'h14, 8'h87);
		add_item(KIND_WRITE, 6'h17, 8'h00);
		add_item(KIND_WRITE, 6'h19, 8'h80);
		add_item(KIND_WRITE, 6'h1A, 8'h80);
		add_item(KIND_WRITE, 6'h1C, 8'h60);
		add_item(KIND_WRITE, 6'h1E, 8'hFF);
		add_item(KIND_WRITE, 6'h21, 8'hFF);
		add_item(KIND_WRITE, 6'h22, 8'h08);
		add_item(KIND_WRITE, 6'h23, 8'h80);
		add_ticks(100);
		drain();
		cfg_write(fvsg_pkg::CFG_POWER, 8'h00);
		add_ticks(40);
		add_item(KIND_WRITE, 6'h1A, 8'h00);
		drain();
		cfg_write(fvsg_pkg::CFG_POWER, 8'h01);
		cfg_write(CFG_NONE, 8'hFF);

		// all four voices set up, then a run of ticks
		add_item(KIND_WRITE, 6'h10, 8'h11);
		add_item(KIND_WRITE, 6'h11, 8'h3E);
		add_item(KIND_WRITE, 6'h12, 8'hF1);
		add_item(KIND_WRITE, 6'h13, 8'h00);
		add_item(KIND_WRITE, 6'h14, 8'h84);
		add_item(KIND_WRITE, 6'h16, 8'hBC);
		add_item(KIND_WRITE, 6'h17, 8'h29);
		add_item(KIND_WRITE, 6'h19, 8'h86);
		add_item(KIND_WRITE, 6'h1A, 8'h80);
		add_item(KIND_WRITE, 6'h1B, 8'hFE);
		add_item(KIND_WRITE, 6'h1C, 8'h20);
		add_item(KIND_WRITE, 6'h33, 8'hA5);
		add_item(KIND_WRITE, 6'h1E, 8'hC5);
		add_item(KIND_WRITE, 6'h21, 8'hF3);
		add_item(KIND_WRITE, 6'h22, 8'h21);
		add_item(KIND_WRITE, 6'h23, 8'h80);
		add_ticks(150);
		drain();
		cfg_write(fvsg_pkg::CFG_MIXER, 8'h00);
		cfg_write(fvsg_pkg::CFG_PAN, 8'h00);
		add_ticks(40);
		drain();

		// random part
		cfg_write(fvsg_pkg::CFG_MIXER, 8'($urandom));
		cfg_write(fvsg_pkg::CFG_PAN, 8'($urandom));
		n = 0;
		while (n < 400) begin
			int before_n;
			before_n = pending.size();
			if ($urandom_range(0, 9) < 7) add_voice_setup();
			else
				for (int i = 0; i < 8; i++)
					add_item(1'($urandom), 6'($urandom_range(0, 63)), 8'($urandom));
			n += pending.size() - before_n;
			if (n > 100 && n < 300 && hold_left == 0 && !hold_req) hold_req = 1;
			while (pending.size() > 64) @(posedge clk);
			if (n > 330) calm = 1;
		end
		drain();

		if (errors == 0) $display("four_voice_sound_generator_test: clean");
		else $display("four_voice_sound_generator_test: errors");
		$finish;
	end
endmodule

[files.f]
rtl/core/fvsg_pkg.sv
rtl/core/fvsg_core.sv
rtl/core/fvsg_scale.sv
rtl/core/four_voice_sound_generator.sv
dv/four_voice_sound_generator_test.sv
